// ----- hw/rtl/ssp_pkg.sv -----
// ----------------------------------------------------------------------------
// Sprite screen projection package
// Shared widths, register indexes and defaults for the projection pipeline.
// ----------------------------------------------------------------------------
package ssp_pkg;

	localparam int RES_W           = 12;
	localparam int CFG_IDX_W       = 1;
	localparam int MAX_RES_DEFAULT = 2048;
	localparam int POS_W           = 16;
	localparam int DEPTH_W         = 24;
	localparam int COORD_W         = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_SCREEN_WIDTH  = 1'b0;
	localparam cfg_idx_t REG_SCREEN_HEIGHT = 1'b1;

	localparam logic [RES_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
	localparam logic [RES_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

endpackage

// ----- hw/rtl/ssp_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined unsigned divider with overflow flag
// One quotient bit per stage after an overflow check, so a new item may enter
// every cycle while en is high; side data travels with each item.
// ----------------------------------------------------------------------------
module ssp_div #(
	parameter int NW = 52,
	parameter int DW = 32,
	parameter int QW = 24,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic          ovf,
	output logic [SW-1:0] out_side
);

	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic          v_s    [0:QW];
	logic [CW-1:0] rem_s  [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic [QW-1:0] q_s    [0:QW];
	logic          ovf_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];

	// The quotient fits in QW bits only when the numerator is below den * 2^QW.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= CW'(num);
			den_s[0]  <= den;
			q_s[0]    <= '0;
			ovf_s[0]  <= CW'(num) >= (CW'(den) << QW);
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		localparam int B = QW - k;
		logic [CW-1:0] trial;
		logic          ge;
		logic [QW-1:0] qbit;

		assign trial = CW'(den_s[k-1]) << B;
		assign ge    = rem_s[k-1] >= trial;
		assign qbit  = QW'(ge) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]    <= ge ? rem_s[k-1] - trial : rem_s[k-1];
				den_s[k]    <= den_s[k-1];
				q_s[k]      <= q_s[k-1] | qbit;
				ovf_s[k]    <= ovf_s[k-1];
				side_s[k]   <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo       = q_s[QW];
	assign ovf       = ovf_s[QW];
	assign out_side  = side_s[QW];

endmodule

// ----- hw/rtl/sprite_screen_projection.sv -----
// ----------------------------------------------------------------------------
// Sprite screen projection
// Transforms a sprite into camera space and gives its screen column, size and
// clamped draw rectangle, one item per cycle while not stalled, through a 50-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     in_valid / in_stall       sprite, player, dir, plane
//  output    out_valid / out_stall     depth, column, size, bounds, degenerate
//  config    wr_en                     wr_index, wr_data
//
// An item is accepted every cycle while in_stall is low. Most of the depth is
// set by the 25-stage transform divider and the 17-stage column
// and size dividers, one quotient bit per stage. The whole pipeline advances
// together and holds only while a result waits in the output register and
// out_stall is high. Reset clears the valid bits and loads the default
// resolution.
module sprite_screen_projection #(
	parameter int MAX_RESOLUTION = ssp_pkg::MAX_RES_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  ssp_pkg::cfg_idx_t                   wr_index,
	input  logic [ssp_pkg::RES_W-1:0]           wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ssp_pkg::POS_W-1:0]           sprite_x,
	input  logic [ssp_pkg::POS_W-1:0]           sprite_y,
	input  logic [ssp_pkg::POS_W-1:0]           player_x,
	input  logic [ssp_pkg::POS_W-1:0]           player_y,
	input  logic signed [ssp_pkg::POS_W-1:0]    dir_x,
	input  logic signed [ssp_pkg::POS_W-1:0]    dir_y,
	input  logic signed [ssp_pkg::POS_W-1:0]    plane_x,
	input  logic signed [ssp_pkg::POS_W-1:0]    plane_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ssp_pkg::DEPTH_W-1:0]  depth,
	output logic signed [ssp_pkg::COORD_W-1:0]  screen_column,
	output logic [ssp_pkg::COORD_W-1:0]         sprite_size,
	output logic signed [ssp_pkg::COORD_W-1:0]  draw_start_x,
	output logic signed [ssp_pkg::COORD_W-1:0]  draw_end_x,
	output logic signed [ssp_pkg::COORD_W-1:0]  draw_start_y,
	output logic signed [ssp_pkg::COORD_W-1:0]  draw_end_y,
	output logic                                degenerate
);

	import ssp_pkg::*;

	logic             en;
	logic [RES_W-1:0] width_q, height_q;
	logic [RES_W-1:0] w_eff, h_eff;
	logic [RES_W-2:0] w_half, h_half;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SCREEN_WIDTH_RST;
			height_q <= SCREEN_HEIGHT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SCREEN_WIDTH:  width_q  <= wr_data;
				REG_SCREEN_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign w_eff  = (32'(width_q) > MAX_RESOLUTION) ? RES_W'(MAX_RESOLUTION) : width_q;
	assign h_eff  = (32'(height_q) > MAX_RESOLUTION) ? RES_W'(MAX_RESOLUTION) : height_q;
	assign w_half = w_eff[RES_W-1:1];
	assign h_half = h_eff[RES_W-1:1];

	// Stages 1 to 3: offsets, products, then the numerators and determinant.
	logic               v_s1, v_s2, v_s3;
	logic signed [16:0] dx_s1, dy_s1;
	logic signed [15:0] dir_x_s1, dir_y_s1, plane_x_s1, plane_y_s1;
	logic signed [32:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [31:0] pe_s2, pf_s2;
	logic signed [33:0] txn_s3, tyn_s3;
	logic signed [32:0] det_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1      <= $signed({1'b0, sprite_x}) - $signed({1'b0, player_x});
			dy_s1      <= $signed({1'b0, sprite_y}) - $signed({1'b0, player_y});
			dir_x_s1   <= dir_x;
			dir_y_s1   <= dir_y;
			plane_x_s1 <= plane_x;
			plane_y_s1 <= plane_y;
			pa_s2      <= dir_y_s1 * dx_s1;
			pb_s2      <= dir_x_s1 * dy_s1;
			pc_s2      <= plane_x_s1 * dy_s1;
			pd_s2      <= plane_y_s1 * dx_s1;
			pe_s2      <= plane_x_s1 * dir_y_s1;
			pf_s2      <= dir_x_s1 * plane_y_s1;
			txn_s3     <= 34'(pa_s2) - 34'(pb_s2);
			tyn_s3     <= 34'(pc_s2) - 34'(pd_s2);
			det_s3     <= 33'(pe_s2) - 33'(pf_s2);
		end
	end

	// Division works on magnitudes; the sign is restored afterwards.
	logic [33:0] txn_mag, tyn_mag;
	logic [31:0] det_mag;
	logic        tx_neg, ty_neg, det_zero;

	assign txn_mag  = txn_s3[33] ? 34'(-txn_s3) : 34'(txn_s3);
	assign tyn_mag  = tyn_s3[33] ? 34'(-tyn_s3) : 34'(tyn_s3);
	assign det_mag  = det_s3[32] ? 32'(-det_s3) : 32'(det_s3);
	assign tx_neg   = txn_s3[33] ^ det_s3[32];
	assign ty_neg   = tyn_s3[33] ^ det_s3[32];
	assign det_zero = (det_s3 == '0);

	logic        tx_v, ty_v, tx_ovf, ty_ovf;
	logic [23:0] tx_q, ty_q;
	logic        tx_side;
	logic [1:0]  ty_side;

	ssp_div #(.NW(52), .DW(32), .QW(24), .SW(1)) u_div_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       ({txn_mag, 18'b0}),
		.den       (det_mag),
		.in_side   (tx_neg),
		.out_valid (tx_v),
		.quo       (tx_q),
		.ovf       (tx_ovf),
		.out_side  (tx_side)
	);

	ssp_div #(.NW(52), .DW(32), .QW(24), .SW(2)) u_div_ty (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       ({tyn_mag, 18'b0}),
		.den       (det_mag),
		.in_side   ({ty_neg, det_zero}),
		.out_valid (ty_v),
		.quo       (ty_q),
		.ovf       (ty_ovf),
		.out_side  (ty_side)
	);

	// Saturate the transform to the Q12.12 range.
	logic signed [23:0] tx_sat, ty_sat;

	always_comb begin
		if (!tx_side) begin
			tx_sat = (tx_ovf || tx_q[23]) ? 24'sh7FFFFF : $signed(tx_q);
		end else begin
			tx_sat = (tx_ovf || (tx_q[23] && |tx_q[22:0])) ? 24'sh800000 : $signed(-tx_q);
		end
		if (!ty_side[1]) begin
			ty_sat = (ty_ovf || ty_q[23]) ? 24'sh7FFFFF : $signed(ty_q);
		end else begin
			ty_sat = (ty_ovf || (ty_q[23] && |ty_q[22:0])) ? 24'sh800000 : $signed(-ty_q);
		end
	end

	// Stages 4 to 6: degenerate test, column numerator sum, then its product.
	logic               v_s4, v_s5, v_s6;
	logic signed [23:0] tx_s4, ty_s4, ty_s5, ty_s6;
	logic               degen_s4, degen_s5, degen_s6;
	logic signed [24:0] sum_s5;
	logic signed [36:0] prod_s6;
	logic               degen4;

	assign degen4 = ty_side[0] || (ty_sat == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= tx_v && ty_v;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s4    <= tx_sat;
			ty_s4    <= degen4 ? '0 : ty_sat;
			degen_s4 <= degen4;
			sum_s5   <= 25'(ty_s4) + 25'(tx_s4);
			ty_s5    <= ty_s4;
			degen_s5 <= degen_s4;
			prod_s6  <= sum_s5 * $signed({1'b0, w_half});
			ty_s6    <= ty_s5;
			degen_s6 <= degen_s5;
		end
	end

	logic [35:0] prod_mag;
	logic [23:0] ty_mag;
	logic        col_neg;

	assign prod_mag = prod_s6[36] ? 36'(-prod_s6) : 36'(prod_s6);
	assign ty_mag   = ty_s6[23] ? 24'(-ty_s6) : 24'(ty_s6);
	assign col_neg  = prod_s6[36] ^ ty_s6[23];

	logic        col_v, size_v, col_ovf, size_ovf;
	logic [15:0] col_q, size_q;
	logic [24:0] col_side;
	logic        size_side;

	ssp_div #(.NW(36), .DW(24), .QW(16), .SW(25)) u_div_col (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (prod_mag),
		.den       (ty_mag),
		.in_side   ({col_neg, ty_s6}),
		.out_valid (col_v),
		.quo       (col_q),
		.ovf       (col_ovf),
		.out_side  (col_side)
	);

	ssp_div #(.NW(24), .DW(24), .QW(16), .SW(1)) u_div_size (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       ({h_eff, 12'b0}),
		.den       (ty_mag),
		.in_side   (degen_s6),
		.out_valid (size_v),
		.quo       (size_q),
		.ovf       (size_ovf),
		.out_side  (size_side)
	);

	// Stage 7: saturated column and size; a degenerate item sits at mid-screen.
	logic signed [15:0] col_sat;

	always_comb begin
		if (!col_side[24]) begin
			col_sat = (col_ovf || col_q[15]) ? 16'sh7FFF : $signed(col_q);
		end else begin
			col_sat = (col_ovf || (col_q[15] && |col_q[14:0])) ? 16'sh8000 : $signed(-col_q);
		end
	end

	logic               v_s7;
	logic signed [23:0] ty_s7;
	logic signed [15:0] col_s7;
	logic [15:0]        size_s7;
	logic               degen_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s7      <= col_v && size_v;
			out_valid <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ty_s7    <= col_side[23:0];
			degen_s7 <= size_side;
			col_s7   <= size_side ? $signed({5'b0, w_half}) : col_sat;
			size_s7  <= size_side ? '0 : (size_ovf ? 16'hFFFF : size_q);
		end
	end

	// Stage 8: draw rectangle, held in the output register.
	logic [14:0]        half;
	logic signed [16:0] sx, ex, sy, ey;
	logic signed [15:0] w_last, h_last;

	assign half   = size_s7[15:1];
	assign sx     = 17'(col_s7) - $signed({2'b0, half});
	assign ex     = 17'(col_s7) + $signed({2'b0, half});
	assign sy     = $signed({6'b0, h_half}) - $signed({2'b0, half});
	assign ey     = $signed({6'b0, h_half}) + $signed({2'b0, half});
	assign w_last = $signed({4'b0, w_eff}) - 16'sd1;
	assign h_last = $signed({4'b0, h_eff}) - 16'sd1;

	always_ff @(posedge clk) begin
		if (en) begin
			depth         <= ty_s7;
			screen_column <= col_s7;
			sprite_size   <= size_s7;
			degenerate    <= degen_s7;
			draw_start_x  <= sx[16] ? '0 : sx[15:0];
			draw_end_x    <= (ex >= $signed({5'b0, w_eff})) ? w_last : ex[15:0];
			draw_start_y  <= sy[16] ? '0 : sy[15:0];
			draw_end_y    <= (ey >= $signed({5'b0, h_eff})) ? h_last : ey[15:0];
		end
	end

endmodule
